[rtl/aesbc_pkg.sv]
package aesbc_pkg;

   localparam int MAX_ROUNDS = 14;
   localparam int RK_DEPTH   = MAX_ROUNDS + 1;
   localparam int RK_AW      = $clog2(RK_DEPTH);
   localparam int CSR_AW     = 6;

   localparam logic [2:0] REG_KEY_SIZE = 3'd0;
   localparam logic [2:0] REG_KEY_W0   = 3'd1;
   localparam logic [2:0] REG_KEY_W1   = 3'd2;
   localparam logic [2:0] REG_KEY_W2   = 3'd3;
   localparam logic [2:0] REG_KEY_W3   = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXPAND,
      ST_INVMIX,
      ST_LOAD,
      ST_ROUND,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      OP_ENC_ROUND,
      OP_DEC_ROUND,
      OP_INVMIX
   } op_type;

   typedef struct packed {
      op_type op;
      logic   last;
   } unit_ctl_type;

   function automatic logic [7:0] xtime(input logic [7:0] a);
      xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] b);
      logic [7:0] p;
      logic [7:0] x;
      p = 8'h00;
      x = a;
      for (int i = 0; i < 4; i++) begin
         if (b[i]) p = p ^ x;
         x = xtime(x);
      end
      gmul = p;
   endfunction

   function automatic logic [7:0] gf_full(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p;
      logic [7:0] x;
      p = 8'h00;
      x = a;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) p = p ^ x;
         x = xtime(x);
      end
      gf_full = p;
   endfunction

   function automatic logic [7:0] ginv(input logic [7:0] a);
      logic [7:0] r;
      logic [7:0] base;
      logic [7:0] e;
      r = 8'h01;
      base = a;
      e = 8'd254;
      for (int i = 0; i < 8; i++) begin
         if (e[i]) r = gf_full(r, base);
         base = gf_full(base, base);
      end
      ginv = (a == 8'h00) ? 8'h00 : r;
   endfunction

   function automatic logic [7:0] rotl(input logic [7:0] v, input int n);
      rotl = (v << n) | (v >> (8 - n));
   endfunction

   // Builds the forward or inverse S-box as a constant table, byte x at bits 8x+7..8x.
   function automatic logic [2047:0] sbox_table(input logic inverse);
      logic [2047:0] tab;
      logic [7:0]    v;
      logic [7:0]    s;
      tab = '0;
      for (int x = 0; x < 256; x++) begin
         v = ginv(8'(x));
         s = v ^ rotl(v, 1) ^ rotl(v, 2) ^ rotl(v, 3) ^ rotl(v, 4) ^ 8'h63;
         if (inverse) tab[{s, 3'b000} +: 8] = 8'(x);
         else tab[8 * x +: 8] = s;
      end
      sbox_table = tab;
   endfunction

   localparam logic [2047:0] SBOX_TAB     = sbox_table(1'b0);
   localparam logic [2047:0] INV_SBOX_TAB = sbox_table(1'b1);

   function automatic logic [7:0] sbox(input logic [7:0] x);
      sbox = SBOX_TAB[{x, 3'b000} +: 8];
   endfunction

   function automatic logic [7:0] inv_sbox(input logic [7:0] s);
      inv_sbox = INV_SBOX_TAB[{s, 3'b000} +: 8];
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      sub_word = {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
   endfunction

   function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
      logic [7:0] a0, a1, a2, a3;
      a0 = c[31:24];
      a1 = c[23:16];
      a2 = c[15:8];
      a3 = c[7:0];
      inv_mix_col = {
         gmul(a0, 4'd14) ^ gmul(a1, 4'd11) ^ gmul(a2, 4'd13) ^ gmul(a3, 4'd9),
         gmul(a0, 4'd9) ^ gmul(a1, 4'd14) ^ gmul(a2, 4'd11) ^ gmul(a3, 4'd13),
         gmul(a0, 4'd13) ^ gmul(a1, 4'd9) ^ gmul(a2, 4'd14) ^ gmul(a3, 4'd11),
         gmul(a0, 4'd11) ^ gmul(a1, 4'd13) ^ gmul(a2, 4'd9) ^ gmul(a3, 4'd14)};
   endfunction

   function automatic logic [31:0] mix_col(input logic [31:0] c);
      logic [7:0] a0, a1, a2, a3;
      a0 = c[31:24];
      a1 = c[23:16];
      a2 = c[15:8];
      a3 = c[7:0];
      mix_col = {
         xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
         a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
         a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
         xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
   endfunction

endpackage

[rtl/aesbc_if.sv]
interface aesbc_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [63:0] data_hi;
   logic [63:0] data_lo;
   modport source (output valid, output func, output data_hi, output data_lo, input ready);
   modport sink (input valid, input func, input data_hi, input data_lo, output ready);
endinterface

interface aesbc_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] result_hi;
   logic [63:0] result_lo;
   modport source (output valid, output result_hi, output result_lo, input ready);
   modport sink (input valid, input result_hi, input result_lo, output ready);
endinterface

[rtl/aesbc_round.sv]
module aesbc_round
   import aesbc_pkg::*;
(
   input  unit_ctl_type   ctl,
   input  logic [127:0]   state,
   input  logic [127:0]   rkey,
   output logic [127:0]   result
);
   // Byte k of the block sits at bits 127-8k; column c is bytes 4c..4c+3.
   logic [7:0]   b   [16];
   logic [7:0]   t   [16];
   logic [127:0] ss;
   logic [127:0] mixed;

   always_comb begin
      for (int k = 0; k < 16; k++) b[k] = state[127 - 8 * k -: 8];
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            if (ctl.op == OP_DEC_ROUND)
               t[c * 4 + r] = inv_sbox(b[((c + 4 - r) % 4) * 4 + r]);
            else
               t[c * 4 + r] = sbox(b[((c + r) % 4) * 4 + r]);
         end
      end
      for (int k = 0; k < 16; k++) ss[127 - 8 * k -: 8] = t[k];
      if (ctl.op == OP_INVMIX) ss = state;
      for (int c = 0; c < 4; c++) begin
         if (ctl.op == OP_ENC_ROUND)
            mixed[127 - 32 * c -: 32] = mix_col(ss[127 - 32 * c -: 32]);
         else
            mixed[127 - 32 * c -: 32] = inv_mix_col(ss[127 - 32 * c -: 32]);
      end
      case (ctl.op)
         OP_INVMIX: result = mixed;
         OP_ENC_ROUND, OP_DEC_ROUND: result = (ctl.last ? ss : mixed) ^ rkey;
         default: result = state;
      endcase
   end
endmodule

[rtl/aesbc_csr.sv]
module aesbc_csr
   import aesbc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [63:0]       pwdata,
   output logic [63:0]       prdata,
   output logic              pready,
   output logic              key_size_256,
   output logic [255:0]      key,
   output logic              wrote
);
   logic        size_ff, size_in;
   logic [63:0] w0_ff, w0_in, w1_ff, w1_in, w2_ff, w2_in, w3_ff, w3_in;
   logic [2:0]  idx;
   logic        wr;

   assign pready = 1'b1;
   assign idx = paddr[CSR_AW-1:3];
   assign wr = psel & penable & pwrite;

   always_comb begin
      size_in = size_ff;
      w0_in = w0_ff;
      w1_in = w1_ff;
      w2_in = w2_ff;
      w3_in = w3_ff;
      wrote = 1'b0;
      if (wr) begin
         wrote = 1'b1;
         case (idx)
            REG_KEY_SIZE: size_in = pwdata[0];
            REG_KEY_W0: w0_in = pwdata;
            REG_KEY_W1: w1_in = pwdata;
            REG_KEY_W2: w2_in = pwdata;
            REG_KEY_W3: w3_in = pwdata;
            default: wrote = 1'b0;
         endcase
      end
      case (idx)
         REG_KEY_SIZE: prdata = {63'd0, size_ff};
         REG_KEY_W0: prdata = w0_ff;
         REG_KEY_W1: prdata = w1_ff;
         REG_KEY_W2: prdata = w2_ff;
         REG_KEY_W3: prdata = w3_ff;
         default: prdata = 64'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= 1'b0;
         w0_ff <= '0;
         w1_ff <= '0;
         w2_ff <= '0;
         w3_ff <= '0;
      end else begin
         size_ff <= size_in;
         w0_ff <= w0_in;
         w1_ff <= w1_in;
         w2_ff <= w2_in;
         w3_ff <= w3_in;
      end
   end

   assign key_size_256 = size_ff;
   assign key = {w0_ff, w1_ff, w2_ff, w3_ff};
endmodule

[rtl/aes_block_cipher_128_256.sv]
// Channel  Dir  Payload                      Handshake
// req      in   func, data_hi, data_lo       req_valid / req_ready
// rsp      out  result_hi, result_lo         rsp_valid / rsp_ready
// csr      in   APB write/read, 64-bit data  psel & penable, pready high
//
// A block passes, from one acceptance to the next, through the accept state, a key-read
// state, Nr + 1 steps of the one shared round unit with one round key read per cycle, and
// a DONE state that moves it into the output register. After a key write, the first block
// first expands the schedule into 4*(Nr+1) key words, then applies InvMixColumns to the
// Nr-1 middle keys. Reset is synchronous; the schedule is marked stale. A waiting result
// holds the next block only at its final handoff; req stays open meanwhile.
module aes_block_cipher_128_256
   import aesbc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   aesbc_req_if.sink         req,
   aesbc_rsp_if.source       rsp,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [63:0]       pwdata,
   output logic [63:0]       prdata,
   output logic              pready
);
   logic         key_size_256;
   logic [255:0] key;
   logic         wrote;

   aesbc_csr u_csr (
      .clock, .reset, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
      .key_size_256, .key, .wrote);

   state_type    st_ff, st_in;
   logic         valid_sched_ff, valid_sched_in;
   logic         big_ff, big_in;
   logic         func_ff, func_in;
   logic [127:0] blk_ff, blk_in;
   logic [3:0]   rnd_ff, rnd_in;
   logic [5:0]   wi_ff, wi_in;
   logic [7:0]   rcon_ff, rcon_in;
   logic [31:0]  win_ff [8];
   logic [31:0]  win_in [8];
   logic [127:0] rk_acc_ff, rk_acc_in;
   logic         out_valid_ff, out_valid_in;
   logic [127:0] out_ff, out_in;

   logic [127:0] enc_mem [RK_DEPTH];
   logic [127:0] dec_mem [RK_DEPTH];
   logic [127:0] enc_rd_ff, dec_rd_ff;
   logic [RK_AW-1:0] rd_addr;
   logic         enc_we, dec_we;
   logic [RK_AW-1:0] enc_wa, dec_wa;
   logic [127:0] enc_wd, dec_wd;

   unit_ctl_type ctl;
   logic [127:0] u_state, u_key, u_res;

   aesbc_round u_round (.ctl, .state(u_state), .rkey(u_key), .result(u_res));

   logic [3:0]  nr;
   logic [5:0]  total;
   logic [3:0]  nk;
   logic [31:0] tw, nw;
   logic [2:0]  wpos;

   assign nr = big_ff ? 4'd14 : 4'd10;
   assign nk = big_ff ? 4'd8 : 4'd4;
   assign total = big_ff ? 6'd60 : 6'd44;

   always_ff @(posedge clock) begin
      if (enc_we) enc_mem[enc_wa] <= enc_wd;
      if (dec_we) dec_mem[dec_wa] <= dec_wd;
      enc_rd_ff <= enc_mem[rd_addr];
      dec_rd_ff <= dec_mem[rd_addr];
   end

   always_comb begin
      st_in = st_ff;
      valid_sched_in = valid_sched_ff & ~wrote;
      big_in = big_ff;
      func_in = func_ff;
      blk_in = blk_ff;
      rnd_in = rnd_ff;
      wi_in = wi_ff;
      rcon_in = rcon_ff;
      win_in = win_ff;
      rk_acc_in = rk_acc_ff;
      out_in = out_ff;
      out_valid_in = out_valid_ff & ~rsp.ready;
      enc_we = 1'b0;
      dec_we = 1'b0;
      enc_wa = '0;
      dec_wa = '0;
      enc_wd = rk_acc_ff;
      dec_wd = rk_acc_ff;
      rd_addr = '0;
      ctl.op = OP_ENC_ROUND;
      ctl.last = 1'b0;
      u_state = blk_ff;
      u_key = func_ff ? dec_rd_ff : enc_rd_ff;
      req.ready = 1'b0;
      wpos = wi_ff[2:0] & (big_ff ? 3'd7 : 3'd3);
      // Next key word from the previous one and the word nk back.
      tw = win_ff[big_ff ? 3'd7 : 3'd3];
      if (wpos == 3'd0)
         tw = sub_word({tw[23:0], tw[31:24]}) ^ {rcon_ff, 24'd0};
      else if (big_ff && wpos == 3'd4)
         tw = sub_word(tw);
      nw = win_ff[0] ^ tw;

      case (st_ff)
         ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               func_in = req.func;
               blk_in = {req.data_hi, req.data_lo};
               if (!valid_sched_ff) begin
                  big_in = key_size_256;
                  for (int i = 0; i < 8; i++) win_in[i] = key[255 - 32 * i -: 32];
                  if (!key_size_256)
                     for (int i = 0; i < 4; i++) win_in[i] = key[255 - 32 * i -: 32];
                  wi_in = 6'd0;
                  rcon_in = 8'h01;
                  st_in = ST_EXPAND;
               end else begin
                  st_in = ST_LOAD;
               end
            end
         end
         ST_EXPAND: begin
            // Emit words in order; each full group of four is a round key.
            if (wi_ff < {2'd0, nk}) nw = win_ff[wi_ff[2:0]];
            rk_acc_in = {rk_acc_ff[95:0], nw};
            if (wi_ff[1:0] == 2'd3) begin
               enc_we = 1'b1;
               dec_we = 1'b1;
               enc_wa = wi_ff[RK_AW+1:2];
               dec_wa = wi_ff[RK_AW+1:2];
               enc_wd = {rk_acc_ff[95:0], nw};
               dec_wd = {rk_acc_ff[95:0], nw};
            end
            if (wi_ff >= {2'd0, nk}) begin
               for (int i = 0; i < 7; i++) win_in[i] = win_ff[i + 1];
               win_in[big_ff ? 3'd7 : 3'd3] = nw;
               if (wpos == 3'd0) rcon_in = xtime(rcon_ff);
            end
            wi_in = wi_ff + 6'd1;
            if (wi_ff == total - 6'd1) begin
               rnd_in = 4'd1;
               st_in = ST_INVMIX;
            end
            rd_addr = 4'd1;
         end
         ST_INVMIX: begin
            // enc_rd_ff holds key rnd_ff; its address was set in the previous cycle.
            rd_addr = rnd_ff[RK_AW-1:0] + 4'd1;
            ctl.op = OP_INVMIX;
            u_state = enc_rd_ff;
            dec_we = 1'b1;
            dec_wa = rnd_ff[RK_AW-1:0];
            dec_wd = u_res;
            rnd_in = rnd_ff + 4'd1;
            if (rnd_ff == nr - 4'd1) begin
               valid_sched_in = ~wrote;
               st_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            rd_addr = func_ff ? nr : 4'd0;
            st_in = ST_ROUND;
            rnd_in = 4'd0;
         end
         ST_ROUND: begin
            // Step 0 only adds the first key; the rest are rounds, the last without MixColumns.
            ctl.op = func_ff ? OP_DEC_ROUND : OP_ENC_ROUND;
            ctl.last = (rnd_ff == nr);
            if (rnd_ff != nr)
               rd_addr = func_ff ? (nr - rnd_ff - 4'd1) : (rnd_ff + 4'd1);
            if (rnd_ff == 4'd0) blk_in = blk_ff ^ u_key;
            else blk_in = u_res;
            rnd_in = rnd_ff + 4'd1;
            if (rnd_ff == nr) st_in = ST_DONE;
         end
         ST_DONE: begin
            if (!out_valid_ff || rsp.ready) begin
               out_in = blk_ff;
               out_valid_in = 1'b1;
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.result_hi = out_ff[127:64];
   assign rsp.result_lo = out_ff[63:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         valid_sched_ff <= 1'b0;
         big_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         valid_sched_ff <= valid_sched_in;
         big_ff <= big_in;
         out_valid_ff <= out_valid_in;
      end
      func_ff <= func_in;
      blk_ff <= blk_in;
      rnd_ff <= rnd_in;
      wi_ff <= wi_in;
      rcon_ff <= rcon_in;
      win_ff <= win_in;
      rk_acc_ff <= rk_acc_in;
      out_ff <= out_in;
   end
endmodule
